@@ design/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PIDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define PIDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pidc_pkg.sv @@
// shared constants, types and command bundle for the clamped pid controller
package pidc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // intermediate terms are saturated to +-2^61
  localparam int SAT_BIT = 61;
  localparam int SAT_W   = SAT_BIT + 2;
  localparam int AMAG_W  = SAT_BIT + 1;

  localparam logic [SAT_W-1:0] SAT_POS = {2'b01, {SAT_BIT{1'b0}}};
  localparam logic [SAT_W-1:0] SAT_NEG = {2'b11, {SAT_BIT{1'b0}}};

  // multiplier consumes this many bits of the second operand per cycle
  localparam int MUL_CHUNK = 16;
  // quotient bits produced per divider cycle
  localparam int DIV_STEP_BITS = 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_INT_INIT = CFG_IDX_W'(6);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_FIN,
    ST_INT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_FIN,
    ST_SUM,
    ST_DONE
  } pidc_state_t;

  typedef enum logic [1:0] {
    MUL_KI_ERR,
    MUL_S1_DT,
    MUL_KP_ERR,
    MUL_KD_DERR
  } pidc_mul_sel_t;

  typedef struct packed {
    logic          load_in;
    logic          mul_load;
    pidc_mul_sel_t mul_sel;
    logic          mul_step;
    logic          fin_mul;
    logic          div_load;
    logic          div_step;
    logic          fin_div;
    logic          int_upd;
    logic          sum_upd;
    logic          out_load;
  } pidc_cmd_t;

endpackage

@@ design/pidc_cfg.sv @@
// configuration register file and restart strobe
module pidc_cfg import pidc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata,
  output logic signed [DATA_WIDTH-1:0] kp,
  output logic signed [DATA_WIDTH-1:0] ki,
  output logic signed [DATA_WIDTH-1:0] kd,
  output logic signed [DATA_WIDTH-1:0] out_min,
  output logic signed [DATA_WIDTH-1:0] out_max,
  output logic signed [DATA_WIDTH-1:0] target,
  output logic                         restart,
  output logic signed [DATA_WIDTH-1:0] restart_value
);

  localparam int DW = DATA_WIDTH;

  logic signed [DW-1:0] kp_r, ki_r, kd_r, out_min_r, out_max_r, target_r, int_init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      out_min_r  <= {1'b1, {(DW-1){1'b0}}};
      out_max_r  <= {1'b0, {(DW-1){1'b1}}};
      target_r   <= '0;
      int_init_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:       kp_r       <= cfg_wdata;
        REG_KI:       ki_r       <= cfg_wdata;
        REG_KD:       kd_r       <= cfg_wdata;
        REG_OUT_MIN:  out_min_r  <= cfg_wdata;
        REG_OUT_MAX:  out_max_r  <= cfg_wdata;
        REG_TARGET:   target_r   <= cfg_wdata;
        REG_INT_INIT: int_init_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // writing the setpoint or the starting integral restarts the loop state
  assign restart       = cfg_we && (cfg_index == REG_TARGET || cfg_index == REG_INT_INIT);
  assign restart_value = (cfg_index == REG_INT_INIT) ? cfg_wdata : int_init_r;

  assign kp      = kp_r;
  assign ki      = ki_r;
  assign kd      = kd_r;
  assign out_min = out_min_r;
  assign out_max = out_max_r;
  assign target  = target_r;

endmodule

@@ design/pidc_ctrl.sv @@
// sequencer: steps the shared multiplier, divider and limiter for each word
module pidc_ctrl import pidc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pidc_cmd_t cmd
);

  localparam int NCH     = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int DIV_CYC = (2 * DATA_WIDTH) / DIV_STEP_BITS;
  localparam int CNT_W   = $clog2(DIV_CYC);

  pidc_state_t   state_r, state_nxt;
  pidc_mul_sel_t ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= MUL_KI_ERR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.mul_sel   = ph_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          ph_nxt      = MUL_KI_ERR;
          state_nxt   = ST_MUL_LOAD;
        end
      end
      ST_MUL_LOAD: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = CNT_W'(NCH - 1);
        state_nxt    = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // derivative product goes straight into the divider
          state_nxt = (ph_r == MUL_KD_DERR) ? ST_DIV_LOAD : ST_MUL_FIN;
        end
      end
      ST_MUL_FIN: begin
        cmd.fin_mul = 1'b1;
        unique case (ph_r)
          MUL_KI_ERR: begin
            ph_nxt    = MUL_S1_DT;
            state_nxt = ST_MUL_LOAD;
          end
          MUL_S1_DT: state_nxt = ST_INT;
          MUL_KP_ERR: begin
            ph_nxt    = MUL_KD_DERR;
            state_nxt = ST_MUL_LOAD;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_INT: begin
        cmd.int_upd = 1'b1;
        ph_nxt      = MUL_KP_ERR;
        state_nxt   = ST_MUL_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = CNT_W'(DIV_CYC - 1);
        state_nxt    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        cmd.fin_div = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/pidc_dp.sv @@
// datapath: error stage, chunked multiplier, radix-4 divider, rounding and limiter
module pidc_dp import pidc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pidc_cmd_t                    cmd,
  input  logic signed [DATA_WIDTH-1:0] in_measured,
  input  logic [DATA_WIDTH-2:0]        in_delta_time,
  input  logic signed [DATA_WIDTH-1:0] kp,
  input  logic signed [DATA_WIDTH-1:0] ki,
  input  logic signed [DATA_WIDTH-1:0] kd,
  input  logic signed [DATA_WIDTH-1:0] out_min,
  input  logic signed [DATA_WIDTH-1:0] out_max,
  input  logic signed [DATA_WIDTH-1:0] target,
  input  logic                         restart,
  input  logic signed [DATA_WIDTH-1:0] restart_value,
  output logic signed [DATA_WIDTH-1:0] out_drive,
  output logic                         out_clamped
);

  localparam int DW    = DATA_WIDTH;
  localparam int NCH   = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BCH_W = NCH * MUL_CHUNK;
  localparam int ACC_W = AMAG_W + BCH_W;
  localparam int DIV_W = 2 * DW;
  localparam int MQ_W  = ACC_W - FRAC_BITS;
  localparam int FQ_A  = (MQ_W > DIV_W) ? MQ_W : DIV_W;
  localparam int FQ_W  = (FQ_A > AMAG_W) ? FQ_A : AMAG_W;
  localparam int INT_W = SAT_W + 1;
  localparam int SUM_W = SAT_W + 2;

  // loop state
  logic signed [DW-1:0] integral_r, prev_r;
  logic                 primed_r;

  // per-word registers
  logic signed [DW-1:0]    err_r;
  logic signed [DW:0]      derr_r;
  logic [DW-2:0]           dt_r;
  logic [AMAG_W-1:0]       a_r;
  logic [BCH_W-1:0]        b_r;
  logic                    neg_r;
  logic [ACC_W-1:0]        acc_r;
  logic [DIV_W-1:0]        dv_r;
  logic [DW-2:0]           rem_r;
  logic signed [SAT_W-1:0] tmp_r, pterm_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [DW-1:0]    drive_r;
  logic                    clamped_r;

  // error stage
  logic signed [DW:0]   diff;
  logic signed [DW-1:0] err_sat, prev_use;
  logic signed [DW:0]   derr_v;

  always_comb begin
    diff = {target[DW-1], target} - {in_measured[DW-1], in_measured};
    if (diff[DW] != diff[DW-1]) begin
      err_sat = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      err_sat = diff[DW-1:0];
    end
    // first word after a restart sees no derivative
    prev_use = primed_r ? prev_r : err_sat;
    derr_v   = {err_sat[DW-1], err_sat} - {prev_use[DW-1], prev_use};
  end

  // multiplier operand select and magnitude
  logic signed [SAT_W-1:0] a_src, a_neg;
  logic signed [DW:0]      b_src, b_neg;
  logic [AMAG_W-1:0]       a_mag;
  logic [DW-1:0]           b_mag;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_KI_ERR: begin
        a_src = {{(SAT_W-DW){ki[DW-1]}}, ki};
        b_src = {err_r[DW-1], err_r};
      end
      MUL_S1_DT: begin
        a_src = tmp_r;
        b_src = {2'b00, dt_r};
      end
      MUL_KP_ERR: begin
        a_src = {{(SAT_W-DW){kp[DW-1]}}, kp};
        b_src = {err_r[DW-1], err_r};
      end
      MUL_KD_DERR: begin
        a_src = {{(SAT_W-DW){kd[DW-1]}}, kd};
        b_src = derr_r;
      end
    endcase
    a_neg = -a_src;
    b_neg = -b_src;
    a_mag = a_src[SAT_W-1] ? a_neg[AMAG_W-1:0] : a_src[AMAG_W-1:0];
    b_mag = b_src[DW] ? b_neg[DW-1:0] : b_src[DW-1:0];
  end

  // one chunk of the second operand per cycle, most significant first
  logic [MUL_CHUNK-1:0]        chunk;
  logic [AMAG_W+MUL_CHUNK-1:0] pp;
  logic [ACC_W-1:0]            acc_nxt;

  assign chunk   = b_r[BCH_W-1 -: MUL_CHUNK];
  assign pp      = a_r * chunk;
  assign acc_nxt = (acc_r << MUL_CHUNK) + ACC_W'(pp);

  // restoring divider by the elapsed time, zero treated as one lsb
  logic [DW-2:0]  dsr;
  logic [DW-1:0]  trial, tdiff;
  logic [DIV_W-1:0] dv_v;
  logic [DW-2:0]  rem_v;

  assign dsr = (dt_r == '0) ? {{(DW-2){1'b0}}, 1'b1} : dt_r;

  always_comb begin
    rem_v = rem_r;
    dv_v  = dv_r;
    trial = '0;
    tdiff = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial = {rem_v, dv_v[DIV_W-1]};
      tdiff = trial - {1'b0, dsr};
      dv_v  = dv_v << 1;
      if (trial >= {1'b0, dsr}) begin
        rem_v   = tdiff[DW-2:0];
        dv_v[0] = 1'b1;
      end else begin
        rem_v = trial[DW-2:0];
      end
    end
  end

  // floor rounding of a sign-magnitude quotient, saturated to +-2^61
  logic [FQ_W-1:0]         fq;
  logic                    rnz, fsat;
  logic [SAT_W-1:0]        q_ext;
  logic signed [SAT_W-1:0] fin_val;

  always_comb begin
    if (cmd.fin_div) begin
      fq  = FQ_W'(dv_r);
      rnz = (rem_r != '0);
    end else begin
      fq  = FQ_W'(acc_r >> FRAC_BITS);
      rnz = |acc_r[FRAC_BITS-1:0];
    end
    fsat  = |fq[FQ_W-1:SAT_BIT];
    q_ext = SAT_W'(fq[SAT_BIT-1:0]);
    if (fsat) begin
      fin_val = neg_r ? SAT_NEG : SAT_POS;
    end else if (neg_r) begin
      // -(q + rnz) as ~q + !rnz
      fin_val = ~q_ext + SAT_W'(!rnz);
    end else begin
      fin_val = q_ext;
    end
  end

  // shared limiter for integral update and final drive
  logic signed [INT_W-1:0] isum;
  logic signed [SUM_W-1:0] lim_in, mn, mx, sum_nxt;
  logic signed [DW-1:0]    lim_val;
  logic                    lim_hit;

  always_comb begin
    isum = {tmp_r[SAT_W-1], tmp_r} + {{(INT_W-DW){integral_r[DW-1]}}, integral_r};
    sum_nxt = {{2{pterm_r[SAT_W-1]}}, pterm_r} + {{2{tmp_r[SAT_W-1]}}, tmp_r}
            + {{(SUM_W-DW){integral_r[DW-1]}}, integral_r};
    lim_in = cmd.int_upd ? {isum[INT_W-1], isum} : sum_r;
    mn     = {{(SUM_W-DW){out_min[DW-1]}}, out_min};
    mx     = {{(SUM_W-DW){out_max[DW-1]}}, out_max};
    if (lim_in < mn) begin
      lim_val = out_min;
      lim_hit = 1'b1;
    end else if (lim_in > mx) begin
      lim_val = out_max;
      lim_hit = 1'b1;
    end else begin
      lim_val = lim_in[DW-1:0];
      lim_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_r     <= '0;
      primed_r   <= 1'b0;
    end else if (restart) begin
      integral_r <= restart_value;
      prev_r     <= '0;
      primed_r   <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        prev_r   <= err_sat;
        primed_r <= 1'b1;
      end
      if (cmd.int_upd) integral_r <= lim_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_r  <= err_sat;
      derr_r <= derr_v;
      dt_r   <= in_delta_time;
    end
    if (cmd.mul_load) begin
      a_r   <= a_mag;
      b_r   <= BCH_W'(b_mag);
      neg_r <= a_src[SAT_W-1] ^ b_src[DW];
      acc_r <= '0;
    end
    if (cmd.mul_step) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << MUL_CHUNK;
    end
    if (cmd.div_load) begin
      dv_r  <= acc_r[DIV_W-1:0];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dv_r  <= dv_v;
      rem_r <= rem_v;
    end
    if (cmd.fin_mul && cmd.mul_sel == MUL_KP_ERR) begin
      pterm_r <= fin_val;
    end else if (cmd.fin_mul || cmd.fin_div) begin
      tmp_r <= fin_val;
    end
    if (cmd.sum_upd) sum_r <= sum_nxt;
    if (cmd.out_load) begin
      drive_r   <= lim_val;
      clamped_r <= lim_hit;
    end
  end

  assign out_drive   = drive_r;
  assign out_clamped = clamped_r;

endmodule

@@ design/pid_controller_clamped.sv @@
// Clamped PID controller, signed fixed point with FRAC_BITS fraction bits. Each input
// word (measured value, elapsed time) produces one output word (drive, clamped flag).
// The block works on one word at a time: no new input word is taken until the current
// one is loaded into the output register. The long steps are the shared 62x16 multiplier,
// which runs four products one 16-bit chunk per cycle, and the divider for the derivative
// term, which retires two quotient bits per cycle over a 2*DATA_WIDTH-bit dividend. A
// finished word waits in the output register while the next input word is taken.
// Configuration writes take effect at the next clock; a write of target or integral_init
// reloads the integral and clears the derivative history.
module pid_controller_clamped import pidc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_measured,
  input  logic [DATA_WIDTH-2:0]        in_delta_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_drive,
  output logic                         out_clamped,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata
);

  pidc_cmd_t cmd;
  logic signed [DATA_WIDTH-1:0] kp, ki, kd, out_min, out_max, target, restart_value;
  logic restart;

  pidc_cfg #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .kp            (kp),
    .ki            (ki),
    .kd            (kd),
    .out_min       (out_min),
    .out_max       (out_max),
    .target        (target),
    .restart       (restart),
    .restart_value (restart_value)
  );

  pidc_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pidc_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_measured   (in_measured),
    .in_delta_time (in_delta_time),
    .kp            (kp),
    .ki            (ki),
    .kd            (kd),
    .out_min       (out_min),
    .out_max       (out_max),
    .target        (target),
    .restart       (restart),
    .restart_value (restart_value),
    .out_drive     (out_drive),
    .out_clamped   (out_clamped)
  );

endmodule

@@ design/pidc_checker.sv @@
// port-level checks for the clamped pid controller, bound to the top level
`include "assert_macros.svh"

module pidc_checker import pidc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_drive,
  input logic                  out_clamped
);

  // a stalled result word holds
  `PIDC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_clamped), "output word changed while stalled")

  // one word at a time: busy right after an accept
  `PIDC_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while a word is in flight")

  // a new result only comes out of a busy block
  `PIDC_ASSERT(a_result_from_work, clk, rst_n, $rose(out_valid) |-> !$past(in_ready), "result appeared without work in flight")

  // reset empties the output register
  `PIDC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind pid_controller_clamped pidc_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_pidc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_drive   (out_drive),
  .out_clamped (out_clamped)
);
